// ===== sv/rgb_lamp_mode_controller_defines.svh =====
// Assertion macros used by the lamp controller checker.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef RGB_LAMP_MODE_CONTROLLER_DEFINES_SVH
`define RGB_LAMP_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define RLMC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define RLMC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define RLMC_ASSERT_NXT_ANY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rlmc_pkg.sv =====
// Shared types, widths and codes for the RGB lamp mode controller.
// No dependencies; the design and checker files refer to it by scoped names.
package rlmc_pkg;

   localparam int TIME_WIDTH      = 32;
   localparam int DUTY_WIDTH      = 8;
   localparam int PERIOD_WIDTH    = 8;
   localparam int WHITE_WIDTH     = 8;
   localparam int WINDOW_WIDTH    = 16;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int ACTION_WIDTH    = 2;
   localparam int MODE_WIDTH      = 2;
   localparam int SEG_WIDTH       = 2;

   localparam int REQ_FIELDS_WIDTH = TIME_WIDTH + 1;
   localparam int REQ_TDATA_WIDTH  = ((REQ_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_WIDTH = 3 * DUTY_WIDTH + PERIOD_WIDTH + 1 + MODE_WIDTH;
   localparam int RSP_TDATA_WIDTH  = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   // Bit positions of the result fields inside rsp_tdata.
   localparam int RSP_RED_LSB    = 0;
   localparam int RSP_GREEN_LSB  = DUTY_WIDTH;
   localparam int RSP_BLUE_LSB   = 2 * DUTY_WIDTH;
   localparam int RSP_PERIOD_LSB = 3 * DUTY_WIDTH;
   localparam int RSP_LAMP_BIT   = RSP_PERIOD_LSB + PERIOD_WIDTH;
   localparam int RSP_MODE_LSB   = RSP_LAMP_BIT + 1;

   localparam logic [DUTY_WIDTH-1:0] DUTY_MAX = '1;

   localparam logic [WHITE_WIDTH-1:0]  WHITE_RED_RST   = WHITE_WIDTH'(255);
   localparam logic [WHITE_WIDTH-1:0]  WHITE_GREEN_RST = WHITE_WIDTH'(200);
   localparam logic [WHITE_WIDTH-1:0]  WHITE_BLUE_RST  = WHITE_WIDTH'(200);
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RST      = WINDOW_WIDTH'(50);
   localparam logic [PERIOD_WIDTH-1:0] SLOW_PERIOD_RST = PERIOD_WIDTH'(50);
   localparam logic [PERIOD_WIDTH-1:0] FAST_PERIOD_RST = PERIOD_WIDTH'(5);
   localparam logic [DUTY_WIDTH-1:0]   CHOSEN_RED_RST   = DUTY_WIDTH'(127);
   localparam logic [DUTY_WIDTH-1:0]   CHOSEN_GREEN_RST = DUTY_WIDTH'(127);
   localparam logic [DUTY_WIDTH-1:0]   CHOSEN_BLUE_RST  = DUTY_WIDTH'(0);

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_TICK   = 2'd0,
      ACT_POWER  = 2'd1,
      ACT_MODE   = 2'd2,
      ACT_SWITCH = 2'd3
   } action_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_NEUTRAL = 2'd0,
      MODE_FIXED   = 2'd1,
      MODE_FADE    = 2'd2
   } mode_type;

   typedef enum logic [SEG_WIDTH-1:0] {
      SEG_RED_BLUE   = 2'd0,
      SEG_BLUE_GREEN = 2'd1,
      SEG_GREEN_RED  = 2'd2
   } segment_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_WHITE_RED   = 3'd0,
      REG_WHITE_GREEN = 3'd1,
      REG_WHITE_BLUE  = 3'd2,
      REG_DEBOUNCE    = 3'd3,
      REG_SLOW_PERIOD = 3'd4,
      REG_FAST_PERIOD = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0] red;
      logic [DUTY_WIDTH-1:0] green;
      logic [DUTY_WIDTH-1:0] blue;
   } colour_type;

   typedef struct packed {
      logic [WHITE_WIDTH-1:0]  white_red;
      logic [WHITE_WIDTH-1:0]  white_green;
      logic [WHITE_WIDTH-1:0]  white_blue;
      logic [WINDOW_WIDTH-1:0] debounce_window_ms;
      logic [PERIOD_WIDTH-1:0] slow_period_ms;
      logic [PERIOD_WIDTH-1:0] fast_period_ms;
   } cfg_type;

   typedef struct packed {
      action_type            action;
      logic [TIME_WIDTH-1:0] time_ms;
      logic                  switch_level;
   } req_item_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0]   red_duty;
      logic [DUTY_WIDTH-1:0]   green_duty;
      logic [DUTY_WIDTH-1:0]   blue_duty;
      logic [PERIOD_WIDTH-1:0] next_period_ms;
      logic                    lamp_is_on;
      mode_type                current_mode;
   } rsp_item_type;

endpackage

// ===== sv/rlmc_wheel.sv =====
// Colour wheel position decode and one-step advance.
// Depends on rlmc_pkg for widths, the segment codes and colour_type.
module rlmc_wheel (
   input  rlmc_pkg::segment_type                 seg,
   input  logic [rlmc_pkg::DUTY_WIDTH-1:0]       step,
   input  rlmc_pkg::colour_type                  hold,
   output rlmc_pkg::colour_type                  colour,
   output rlmc_pkg::segment_type                 seg_next,
   output logic [rlmc_pkg::DUTY_WIDTH-1:0]       step_next
);

   logic [rlmc_pkg::DUTY_WIDTH-1:0] inv;

   always_comb begin
      inv    = rlmc_pkg::DUTY_MAX - step;
      colour = hold;
      case (seg)
         rlmc_pkg::SEG_RED_BLUE: begin
            colour.red   = inv;
            colour.green = '0;
            colour.blue  = step;
         end
         rlmc_pkg::SEG_BLUE_GREEN: begin
            colour.red   = '0;
            colour.green = step;
            colour.blue  = inv;
         end
         rlmc_pkg::SEG_GREEN_RED: begin
            colour.red   = step;
            colour.green = inv;
            colour.blue  = '0;
         end
         default: begin
            colour = hold;
         end
      endcase
   end

   // At the end of a segment the step wraps and the wheel moves on.
   always_comb begin
      seg_next  = seg;
      step_next = step + rlmc_pkg::DUTY_WIDTH'(1);
      if (step == rlmc_pkg::DUTY_MAX) begin
         step_next = '0;
         case (seg)
            rlmc_pkg::SEG_RED_BLUE:   seg_next = rlmc_pkg::SEG_BLUE_GREEN;
            rlmc_pkg::SEG_BLUE_GREEN: seg_next = rlmc_pkg::SEG_GREEN_RED;
            rlmc_pkg::SEG_GREEN_RED:  seg_next = rlmc_pkg::SEG_RED_BLUE;
            default:                  seg_next = rlmc_pkg::SEG_BLUE_GREEN;
         endcase
      end
   end

endmodule

// ===== sv/rlmc_ctrl.sv =====
// Lamp state registers, button debounce and tick result logic.
// Depends on rlmc_pkg and instantiates rlmc_wheel for the pick and fade wheels.
module rlmc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  rlmc_pkg::req_item_type item,
   input  rlmc_pkg::cfg_type      cfg,
   output rlmc_pkg::rsp_item_type result
);

   logic                              lamp_on_ff, lamp_on_in;
   rlmc_pkg::mode_type                mode_ff, mode_in, mode_step;
   logic [rlmc_pkg::TIME_WIDTH-1:0]   last_power_ff, last_power_in;
   logic [rlmc_pkg::TIME_WIDTH-1:0]   last_mode_ff, last_mode_in;
   logic [rlmc_pkg::TIME_WIDTH-1:0]   last_switch_ff, last_switch_in;
   logic                              prev_level_ff, prev_level_in;
   logic                              picking_ff, picking_in;
   logic [rlmc_pkg::DUTY_WIDTH-1:0]   pick_step_ff, pick_step_in, pick_step_next;
   rlmc_pkg::segment_type             pick_seg_ff, pick_seg_in, pick_seg_next;
   rlmc_pkg::colour_type              chosen_ff, chosen_in, chosen_now;
   logic [rlmc_pkg::DUTY_WIDTH-1:0]   fade_step_ff, fade_step_in, fade_step_next;
   rlmc_pkg::segment_type             fade_seg_ff, fade_seg_in, fade_seg_next;
   rlmc_pkg::colour_type              pick_colour, fade_colour, out_colour;

   logic [rlmc_pkg::TIME_WIDTH-1:0]   power_diff, mode_diff, switch_diff;
   logic [rlmc_pkg::TIME_WIDTH-1:0]   window;
   logic                              power_ok, mode_ok, switch_ok, tick_fire;

   rlmc_wheel u_pick_wheel (
      .seg       (pick_seg_ff),
      .step      (pick_step_ff),
      .hold      (chosen_ff),
      .colour    (pick_colour),
      .seg_next  (pick_seg_next),
      .step_next (pick_step_next)
   );

   rlmc_wheel u_fade_wheel (
      .seg       (fade_seg_ff),
      .step      (fade_step_ff),
      .hold      ('0),
      .colour    (fade_colour),
      .seg_next  (fade_seg_next),
      .step_next (fade_step_next)
   );

   // Timestamps wrap, so the elapsed time is a plain modular difference.
   assign window      = rlmc_pkg::TIME_WIDTH'(cfg.debounce_window_ms);
   assign power_diff  = item.time_ms - last_power_ff;
   assign mode_diff   = item.time_ms - last_mode_ff;
   assign switch_diff = item.time_ms - last_switch_ff;
   assign power_ok    = power_diff >= window;
   assign mode_ok     = mode_diff >= window;
   assign switch_ok   = switch_diff >= window;
   assign tick_fire   = fire && (item.action == rlmc_pkg::ACT_TICK);

   always_comb begin
      case (mode_ff)
         rlmc_pkg::MODE_NEUTRAL: mode_step = rlmc_pkg::MODE_FIXED;
         rlmc_pkg::MODE_FIXED:   mode_step = rlmc_pkg::MODE_FADE;
         rlmc_pkg::MODE_FADE:    mode_step = rlmc_pkg::MODE_NEUTRAL;
         default:                mode_step = rlmc_pkg::MODE_FIXED;
      endcase
   end

   // The fixed colour follows the pick wheel before the tick reports it.
   assign chosen_now = (lamp_on_ff && picking_ff) ? pick_colour : chosen_ff;

   always_comb begin
      out_colour = '0;
      if (lamp_on_ff) begin
         case (mode_ff)
            rlmc_pkg::MODE_NEUTRAL: begin
               out_colour.red   = rlmc_pkg::DUTY_WIDTH'(cfg.white_red);
               out_colour.green = rlmc_pkg::DUTY_WIDTH'(cfg.white_green);
               out_colour.blue  = rlmc_pkg::DUTY_WIDTH'(cfg.white_blue);
            end
            rlmc_pkg::MODE_FIXED: out_colour = chosen_now;
            rlmc_pkg::MODE_FADE:  out_colour = fade_colour;
            default:              out_colour = '0;
         endcase
      end
   end

   always_comb begin
      result.red_duty       = out_colour.red;
      result.green_duty     = out_colour.green;
      result.blue_duty      = out_colour.blue;
      result.next_period_ms = picking_ff ? cfg.fast_period_ms : cfg.slow_period_ms;
      result.lamp_is_on     = lamp_on_ff;
      result.current_mode   = mode_ff;
   end

   always_comb begin
      lamp_on_in     = lamp_on_ff;
      mode_in        = mode_ff;
      last_power_in  = last_power_ff;
      last_mode_in   = last_mode_ff;
      last_switch_in = last_switch_ff;
      prev_level_in  = prev_level_ff;
      picking_in     = picking_ff;
      pick_step_in   = pick_step_ff;
      pick_seg_in    = pick_seg_ff;
      chosen_in      = chosen_ff;
      fade_step_in   = fade_step_ff;
      fade_seg_in    = fade_seg_ff;
      if (fire) begin
         case (item.action)
            rlmc_pkg::ACT_POWER: begin
               last_power_in = item.time_ms;
               if (power_ok) begin
                  lamp_on_in = !lamp_on_ff;
               end
            end
            rlmc_pkg::ACT_MODE: begin
               last_mode_in = item.time_ms;
               if (mode_ok) begin
                  mode_in = mode_step;
               end
            end
            rlmc_pkg::ACT_SWITCH: begin
               last_switch_in = item.time_ms;
               if (switch_ok) begin
                  if (!prev_level_ff && item.switch_level) begin
                     picking_in = 1'b1;
                  end
                  if (prev_level_ff && !item.switch_level) begin
                     picking_in = 1'b0;
                  end
                  prev_level_in = item.switch_level;
               end
            end
            default: begin
            end
         endcase
      end
      if (tick_fire && lamp_on_ff) begin
         if (picking_ff) begin
            chosen_in    = pick_colour;
            pick_step_in = pick_step_next;
            pick_seg_in  = pick_seg_next;
         end
         if (mode_ff == rlmc_pkg::MODE_FADE) begin
            fade_step_in = fade_step_next;
            fade_seg_in  = fade_seg_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_on_ff       <= 1'b0;
         mode_ff          <= rlmc_pkg::MODE_NEUTRAL;
         last_power_ff    <= '0;
         last_mode_ff     <= '0;
         last_switch_ff   <= '0;
         prev_level_ff    <= 1'b0;
         picking_ff       <= 1'b0;
         pick_step_ff     <= '0;
         pick_seg_ff      <= rlmc_pkg::SEG_RED_BLUE;
         chosen_ff.red    <= rlmc_pkg::CHOSEN_RED_RST;
         chosen_ff.green  <= rlmc_pkg::CHOSEN_GREEN_RST;
         chosen_ff.blue   <= rlmc_pkg::CHOSEN_BLUE_RST;
         fade_step_ff     <= '0;
         fade_seg_ff      <= rlmc_pkg::SEG_RED_BLUE;
      end else begin
         lamp_on_ff     <= lamp_on_in;
         mode_ff        <= mode_in;
         last_power_ff  <= last_power_in;
         last_mode_ff   <= last_mode_in;
         last_switch_ff <= last_switch_in;
         prev_level_ff  <= prev_level_in;
         picking_ff     <= picking_in;
         pick_step_ff   <= pick_step_in;
         pick_seg_ff    <= pick_seg_in;
         chosen_ff      <= chosen_in;
         fade_step_ff   <= fade_step_in;
         fade_seg_ff    <= fade_seg_in;
      end
   end

endmodule

// ===== sv/rgb_lamp_mode_controller.sv =====
// RGB lamp mode controller: one event per req transaction (tick, power press, mode
// press, colour switch change), one result per tick and none for the other events.
// An event enters an input register and is applied to the lamp state as it leaves it,
// which a tick does only when the output register is free or being taken; a tick's
// result is held in the output register until taken, and rsp_tvalid is driven from
// that register. One event is accepted every cycle; only a stalled result held in
// the output register while another tick waits behind it holds the req side back.
// Configuration writes take effect at the next clock edge.
// Depends on rlmc_pkg, rlmc_ctrl and rlmc_wheel.
module rgb_lamp_mode_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // time_ms, switch_level, zero padding
   input  logic [rlmc_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // action
   input  logic [rlmc_pkg::ACTION_WIDTH-1:0]      req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // red_duty, green_duty, blue_duty, next_period_ms, lamp_is_on, current_mode,
   // zero padding
   output logic [rlmc_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                   csr_we,
   input  logic [rlmc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [rlmc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   rlmc_pkg::cfg_type      cfg_ff, cfg_in;
   logic                   in_valid_ff, in_valid_in;
   rlmc_pkg::req_item_type in_item_ff, in_item_in;
   logic                   out_valid_ff, out_valid_in;
   rlmc_pkg::rsp_item_type out_item_ff, out_item_in, step_result;
   logic                   req_accept, step_fire, step_is_tick;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rlmc_pkg::REG_WHITE_RED:
               cfg_in.white_red = csr_wdata[rlmc_pkg::WHITE_WIDTH-1:0];
            rlmc_pkg::REG_WHITE_GREEN:
               cfg_in.white_green = csr_wdata[rlmc_pkg::WHITE_WIDTH-1:0];
            rlmc_pkg::REG_WHITE_BLUE:
               cfg_in.white_blue = csr_wdata[rlmc_pkg::WHITE_WIDTH-1:0];
            rlmc_pkg::REG_DEBOUNCE:
               cfg_in.debounce_window_ms = csr_wdata[rlmc_pkg::WINDOW_WIDTH-1:0];
            rlmc_pkg::REG_SLOW_PERIOD:
               cfg_in.slow_period_ms = csr_wdata[rlmc_pkg::PERIOD_WIDTH-1:0];
            rlmc_pkg::REG_FAST_PERIOD:
               cfg_in.fast_period_ms = csr_wdata[rlmc_pkg::PERIOD_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // An event other than a tick never needs the output register, so it always moves on.
   assign step_is_tick = (in_item_ff.action == rlmc_pkg::ACT_TICK);
   assign step_fire    = in_valid_ff && (!step_is_tick || !out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || step_fire;
   assign req_accept   = req_tvalid && req_tready;

   always_comb begin
      in_item_in              = in_item_ff;
      in_valid_in             = in_valid_ff;
      if (step_fire) begin
         in_valid_in = 1'b0;
      end
      if (req_accept) begin
         in_valid_in             = 1'b1;
         in_item_in.action       = rlmc_pkg::action_type'(req_tuser);
         in_item_in.time_ms      = req_tdata[rlmc_pkg::TIME_WIDTH-1:0];
         in_item_in.switch_level = req_tdata[rlmc_pkg::TIME_WIDTH];
      end
   end

   rlmc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (step_fire),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_comb begin
      out_item_in  = out_item_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (step_fire && step_is_tick) begin
         out_item_in  = step_result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.white_red          <= rlmc_pkg::WHITE_RED_RST;
         cfg_ff.white_green        <= rlmc_pkg::WHITE_GREEN_RST;
         cfg_ff.white_blue         <= rlmc_pkg::WHITE_BLUE_RST;
         cfg_ff.debounce_window_ms <= rlmc_pkg::WINDOW_RST;
         cfg_ff.slow_period_ms     <= rlmc_pkg::SLOW_PERIOD_RST;
         cfg_ff.fast_period_ms     <= rlmc_pkg::FAST_PERIOD_RST;
         in_valid_ff               <= 1'b0;
         out_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rlmc_pkg::RSP_TDATA_WIDTH'({out_item_ff.current_mode,
                                                   out_item_ff.lamp_is_on,
                                                   out_item_ff.next_period_ms,
                                                   out_item_ff.blue_duty,
                                                   out_item_ff.green_duty,
                                                   out_item_ff.red_duty});

endmodule

// ===== sv/rlmc_checker.sv =====
// Port-level checks for the RGB lamp mode controller, bound to the top level.
// Depends on rlmc_pkg and the assertion macros in rgb_lamp_mode_controller_defines.svh.
`include "rgb_lamp_mode_controller_defines.svh"

module rlmc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [rlmc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   logic [rlmc_pkg::DUTY_WIDTH-1:0] red, green, blue;
   logic [rlmc_pkg::MODE_WIDTH-1:0] mode;
   logic                            lamp;
   logic                            stalled, all_dark, one_dark, wheel_shown;

   assign red   = rsp_tdata[rlmc_pkg::RSP_RED_LSB +: rlmc_pkg::DUTY_WIDTH];
   assign green = rsp_tdata[rlmc_pkg::RSP_GREEN_LSB +: rlmc_pkg::DUTY_WIDTH];
   assign blue  = rsp_tdata[rlmc_pkg::RSP_BLUE_LSB +: rlmc_pkg::DUTY_WIDTH];
   assign lamp  = rsp_tdata[rlmc_pkg::RSP_LAMP_BIT];
   assign mode  = rsp_tdata[rlmc_pkg::RSP_MODE_LSB +: rlmc_pkg::MODE_WIDTH];

   assign stalled     = rsp_tvalid && !rsp_tready;
   assign all_dark    = (red == '0) && (green == '0) && (blue == '0);
   assign one_dark    = (red == '0) || (green == '0) || (blue == '0);
   assign wheel_shown = rsp_tvalid && lamp && (mode != rlmc_pkg::MODE_NEUTRAL);

   // Both pipeline registers are empty after reset, so results stop and events flow.
   `RLMC_ASSERT_NXT_ANY(a_reset_empty, reset, !rsp_tvalid && req_tready, "not empty after reset")

   `RLMC_ASSERT_NXT(a_rsp_hold, stalled, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `RLMC_ASSERT_IMP(a_lamp_off_dark, rsp_tvalid && !lamp, all_dark, "duty nonzero with lamp off")

   // Each wheel position leaves one channel dark; so does the fixed colour, picked or reset.
   `RLMC_ASSERT_IMP(a_wheel_one_dark, wheel_shown, one_dark, "wheel colour with all channels lit")

endmodule

bind rgb_lamp_mode_controller rlmc_checker u_rlmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
